@@ rtl/scp_pkg.sv @@
// Shared types and constants of the sprite camera projection block.
package scp_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_CAMERA_POS_X = 3'd0;
    localparam logic [2:0] CFG_CAMERA_POS_Y = 3'd1;
    localparam logic [2:0] CFG_VIEW_DIR_X   = 3'd2;
    localparam logic [2:0] CFG_VIEW_DIR_Y   = 3'd3;
    localparam logic [2:0] CFG_CAM_PLANE_X  = 3'd4;
    localparam logic [2:0] CFG_CAM_PLANE_Y  = 3'd5;

    // Camera-space division: quotient bits, divisor width and saturation cap.
    localparam int Q1_W   = 48;
    localparam int DEN1_W = 49;
    localparam logic [Q1_W-1:0] QCAP = 48'h8000_0000_0000;

    // Screen-space division: quotient bits and divisor width.
    localparam int Q2_W   = 30;
    localparam int DEN2_W = 48;

    // Numerator of the vertical shift, 200 in Q16.16.
    localparam logic [Q2_W-1:0] VSHIFT_NUM = 30'(200 * 65536);

    typedef struct packed {
        logic [2:0]  index;
        logic [31:0] value;
    } t_cfg_write;

    typedef struct packed {
        logic [7:0]         sprite_tag;
        logic signed [31:0] sprite_pos_x;
        logic signed [31:0] sprite_pos_y;
    } t_sprite_in;

    typedef struct packed {
        logic [7:0]         tag_out;
        logic               visible;
        logic [30:0]        depth;
        logic [14:0]        sprite_size;
        logic signed [15:0] bound_left;
        logic signed [15:0] bound_right;
        logic signed [15:0] bound_top;
        logic signed [15:0] bound_bottom;
        logic signed [15:0] clip_left;
        logic signed [15:0] clip_right;
        logic signed [15:0] clip_top;
        logic signed [15:0] clip_bottom;
    } t_sprite_out;

    // Sideband carried through the camera-space divider.
    typedef struct packed {
        logic [7:0] tag;
        logic       neg_x;
        logic       neg_y;
        logic       det_zero;
        logic       sat_x;
        logic       sat_y;
    } t_div1_side;

    // Sideband carried through the screen-space divider.
    typedef struct packed {
        logic [7:0]        tag;
        logic              vis;
        logic [DEN2_W-1:0] ty;
        logic              neg;
        logic              presat;
    } t_div2_side;

endpackage

@@ rtl/scp_stream.sv @@
// Valid/ready channel interface carrying one payload per transaction.
interface scp_stream #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/sprite_camera_projection.sv @@
// Top level of the sprite camera projection pipeline.
//
// Usage: sprites enter on i_sprite (tag and world position, Q16.16) and one
// result per sprite leaves on o_result: visibility, depth, size, raw screen
// bounds and the bounds clipped to the screen. The camera registers are
// written through i_cfg, which is always ready; write them only while no
// sprite is in flight.
// Throughput: one sprite per cycle while the receiver does not stall. The
// pipeline depth is set by the two bit-per-stage dividers: 48 stages for the
// camera-space quotients and 30 stages for the screen-space quotients, plus
// ten stages of products, sums, saturation and clipping.
// Reset clears every valid bit and the camera registers to zero.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and i_sprite.ready drops; nothing is lost or repeated. Empty slots in the
// pipe still advance whenever the output register is free.
module sprite_camera_projection
    import scp_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 1024,
    parameter int SCREEN_HEIGHT = 768
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    scp_stream.sink    i_cfg,
    scp_stream.sink    i_sprite,
    scp_stream.source  o_result
);

    localparam int HALF_W  = SCREEN_WIDTH / 2;
    localparam int HALF_H  = SCREEN_HEIGHT / 2;
    localparam int HW_BITS = $clog2(HALF_W + 1);
    localparam int NUM_W   = 49 + HW_BITS;
    localparam logic [Q2_W-1:0] SIZE_NUM = Q2_W'(SCREEN_HEIGHT * 65536);

    function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
        if (v > 34'sd32767) begin
            return 16'sh7fff;
        end else if (v < -34'sd32768) begin
            return 16'sh8000;
        end else begin
            return v[15:0];
        end
    endfunction

    // Camera registers.
    logic signed [31:0] r_cam_pos_x, r_cam_pos_y;
    logic signed [31:0] r_view_dir_x, r_view_dir_y;
    logic signed [31:0] r_cam_plane_x, r_cam_plane_y;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_pos_x   <= '0;
            r_cam_pos_y   <= '0;
            r_view_dir_x  <= '0;
            r_view_dir_y  <= '0;
            r_cam_plane_x <= '0;
            r_cam_plane_y <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                CFG_CAMERA_POS_X: r_cam_pos_x   <= i_cfg.data.value;
                CFG_CAMERA_POS_Y: r_cam_pos_y   <= i_cfg.data.value;
                CFG_VIEW_DIR_X:   r_view_dir_x  <= i_cfg.data.value;
                CFG_VIEW_DIR_Y:   r_view_dir_y  <= i_cfg.data.value;
                CFG_CAM_PLANE_X:  r_cam_plane_x <= i_cfg.data.value;
                CFG_CAM_PLANE_Y:  r_cam_plane_y <= i_cfg.data.value;
                default: ;
            endcase
        end
    end

    // The pipe advances whenever the output register is empty or being taken.
    logic en;
    logic r_out_valid;
    t_sprite_out r_out;

    assign en             = !r_out_valid || o_result.ready;
    assign i_sprite.ready = en;

    // Stage A: offsets from the camera.
    logic              r_va;
    logic [7:0]        r_a_tag;
    logic signed [32:0] r_a_ex, r_a_ey;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (en) begin
            r_va <= i_sprite.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_tag <= i_sprite.data.sprite_tag;
            r_a_ex  <= 33'(i_sprite.data.sprite_pos_x) - 33'(r_cam_pos_x);
            r_a_ey  <= 33'(i_sprite.data.sprite_pos_y) - 33'(r_cam_pos_y);
        end
    end

    // Stage B: the six products, floored to Q16.16.
    logic               r_vb;
    logic [7:0]         r_b_tag;
    logic signed [47:0] r_b_pd, r_b_dp;
    logic signed [48:0] r_b_dyex, r_b_dxey, r_b_pxey, r_b_pyex;
    logic signed [63:0] prod_pd, prod_dp;
    logic signed [64:0] prod_dyex, prod_dxey, prod_pxey, prod_pyex;

    assign prod_pd   = r_cam_plane_x * r_view_dir_y;
    assign prod_dp   = r_view_dir_x * r_cam_plane_y;
    assign prod_dyex = 65'(r_view_dir_y) * 65'(r_a_ex);
    assign prod_dxey = 65'(r_view_dir_x) * 65'(r_a_ey);
    assign prod_pxey = 65'(r_cam_plane_x) * 65'(r_a_ey);
    assign prod_pyex = 65'(r_cam_plane_y) * 65'(r_a_ex);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (en) begin
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_tag  <= r_a_tag;
            r_b_pd   <= prod_pd[63:16];
            r_b_dp   <= prod_dp[63:16];
            r_b_dyex <= prod_dyex[64:16];
            r_b_dxey <= prod_dxey[64:16];
            r_b_pxey <= prod_pxey[64:16];
            r_b_pyex <= prod_pyex[64:16];
        end
    end

    // Stage C: determinant and the two numerators.
    logic               r_vc;
    logic [7:0]         r_c_tag;
    logic signed [48:0] r_c_det;
    logic signed [49:0] r_c_nx, r_c_ny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
        end else if (en) begin
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_tag <= r_b_tag;
            r_c_det <= 49'(r_b_pd) - 49'(r_b_dp);
            r_c_nx  <= 50'(r_b_dyex) - 50'(r_b_dxey);
            r_c_ny  <= 50'(r_b_pxey) - 50'(r_b_pyex);
        end
    end

    // Stage D: magnitudes, signs, overflow checks and divider seeds.
    logic [49:0] nx_abs, ny_abs;
    logic [48:0] det_abs;

    assign nx_abs  = r_c_nx[49] ? 50'(-r_c_nx) : 50'(r_c_nx);
    assign ny_abs  = r_c_ny[49] ? 50'(-r_c_ny) : 50'(r_c_ny);
    assign det_abs = r_c_det[48] ? 49'(-r_c_det) : 49'(r_c_det);

    logic                          r_vd;
    t_div1_side                    r_d_side;
    logic [DEN1_W-1:0]             r_d_den;
    logic [1:0][DEN1_W-1:0]        r_d_rem;
    logic [1:0][Q1_W-1:0]          r_d_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= 1'b0;
        end else if (en) begin
            r_vd <= r_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_side.tag      <= r_c_tag;
            r_d_side.neg_x    <= r_c_nx[49] ^ r_c_det[48];
            r_d_side.neg_y    <= r_c_ny[49] ^ r_c_det[48];
            r_d_side.det_zero <= (r_c_det == '0);
            r_d_side.sat_x    <= {31'b0, nx_abs} >= {det_abs, 32'b0};
            r_d_side.sat_y    <= {31'b0, ny_abs} >= {det_abs, 32'b0};
            r_d_den           <= det_abs;
            r_d_rem[0]        <= DEN1_W'(nx_abs[49:32]);
            r_d_rem[1]        <= DEN1_W'(ny_abs[49:32]);
            r_d_quo[0]        <= {nx_abs[31:0], 16'b0};
            r_d_quo[1]        <= {ny_abs[31:0], 16'b0};
        end
    end

    // Camera-space division: tx and ty magnitudes.
    logic                 d1_valid;
    logic [$bits(t_div1_side)-1:0] d1_side_bits;
    t_div1_side           d1_side;
    logic [1:0][Q1_W-1:0] d1_quo;

    scp_div_pipe #(
        .QW (Q1_W),
        .RW (DEN1_W),
        .LN (2),
        .SW ($bits(t_div1_side))
    ) u_div_cam (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_vd),
        .i_side  (r_d_side),
        .i_den   (r_d_den),
        .i_rem   (r_d_rem),
        .i_quo   (r_d_quo),
        .o_valid (d1_valid),
        .o_side  (d1_side_bits),
        .o_quo   (d1_quo)
    );

    assign d1_side = t_div1_side'(d1_side_bits);

    // Stage E: saturate and sign the quotients.
    logic [Q1_W-1:0] mag_x, mag_y;

    assign mag_x = (d1_side.sat_x || d1_quo[0] > QCAP) ? QCAP : d1_quo[0];
    assign mag_y = (d1_side.sat_y || d1_quo[1] > QCAP) ? QCAP : d1_quo[1];

    logic               r_ve;
    logic [7:0]         r_e_tag;
    logic               r_e_vis;
    logic [Q1_W-1:0]    r_e_ty;
    logic signed [48:0] r_e_tx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ve <= 1'b0;
        end else if (en) begin
            r_ve <= d1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_tag <= d1_side.tag;
            r_e_vis <= !d1_side.det_zero && mag_y != '0 && !d1_side.neg_y;
            r_e_ty  <= mag_y;
            r_e_tx  <= d1_side.neg_x ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
        end
    end

    // Stage F1: ty + tx, split into sign and magnitude.
    logic signed [49:0] sum_f;

    assign sum_f = $signed({2'b0, r_e_ty}) + 50'(r_e_tx);

    logic            r_vf1;
    logic [7:0]      r_f1_tag;
    logic            r_f1_vis;
    logic [Q1_W-1:0] r_f1_ty;
    logic            r_f1_neg;
    logic [48:0]     r_f1_abs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf1 <= 1'b0;
        end else if (en) begin
            r_vf1 <= r_ve;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1_tag <= r_e_tag;
            r_f1_vis <= r_e_vis;
            r_f1_ty  <= r_e_ty;
            r_f1_neg <= sum_f[49];
            r_f1_abs <= sum_f[49] ? 49'(-sum_f) : 49'(sum_f);
        end
    end

    // Stage F2: scale by half the screen width.
    logic             r_vf2;
    logic [7:0]       r_f2_tag;
    logic             r_f2_vis;
    logic [Q1_W-1:0]  r_f2_ty;
    logic             r_f2_neg;
    logic [NUM_W-1:0] r_f2_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf2 <= 1'b0;
        end else if (en) begin
            r_vf2 <= r_vf1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f2_tag <= r_f1_tag;
            r_f2_vis <= r_f1_vis;
            r_f2_ty  <= r_f1_ty;
            r_f2_neg <= r_f1_neg;
            r_f2_num <= NUM_W'(r_f1_abs) * NUM_W'(HALF_W);
        end
    end

    // Stage F3: overflow check and seeds of the screen-space division.
    logic                   r_vf3;
    t_div2_side             r_f3_side;
    logic [2:0][DEN2_W-1:0] r_f3_rem;
    logic [2:0][Q2_W-1:0]   r_f3_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf3 <= 1'b0;
        end else if (en) begin
            r_vf3 <= r_vf2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f3_side.tag    <= r_f2_tag;
            r_f3_side.vis    <= r_f2_vis;
            r_f3_side.ty     <= r_f2_ty;
            r_f3_side.neg    <= r_f2_neg;
            r_f3_side.presat <= 78'(r_f2_num) >= {r_f2_ty, 30'b0};
            r_f3_rem[0]      <= DEN2_W'(r_f2_num >> Q2_W);
            r_f3_rem[1]      <= '0;
            r_f3_rem[2]      <= '0;
            r_f3_quo[0]      <= r_f2_num[Q2_W-1:0];
            r_f3_quo[1]      <= SIZE_NUM;
            r_f3_quo[2]      <= VSHIFT_NUM;
        end
    end

    // Screen-space division: column, size and vertical shift.
    logic                 d2_valid;
    logic [$bits(t_div2_side)-1:0] d2_side_bits;
    t_div2_side           d2_side;
    logic [2:0][Q2_W-1:0] d2_quo;

    scp_div_pipe #(
        .QW (Q2_W),
        .RW (DEN2_W),
        .LN (3),
        .SW ($bits(t_div2_side))
    ) u_div_scr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_vf3),
        .i_side  (r_f3_side),
        .i_den   (r_f3_side.ty),
        .i_rem   (r_f3_rem),
        .i_quo   (r_f3_quo),
        .o_valid (d2_valid),
        .o_side  (d2_side_bits),
        .o_quo   (d2_quo)
    );

    assign d2_side = t_div2_side'(d2_side_bits);

    // Stage G: screen column and the four raw bounds.
    logic signed [33:0] scr_x, half_sz, vsh;

    always_comb begin
        if (d2_side.presat) begin
            scr_x = d2_side.neg ? -34'sd1073741824 : 34'sd1073741824;
        end else if (d2_side.neg) begin
            scr_x = -$signed({4'b0, d2_quo[0]});
        end else begin
            scr_x = $signed({4'b0, d2_quo[0]});
        end
    end

    assign half_sz = $signed({4'b0, d2_quo[1] >> 1});
    assign vsh     = $signed({4'b0, d2_quo[2]});

    logic               r_vg;
    logic [7:0]         r_g_tag;
    logic               r_g_vis;
    logic [DEN2_W-1:0]  r_g_ty;
    logic [Q2_W-1:0]    r_g_size;
    logic signed [33:0] r_g_left, r_g_right, r_g_top, r_g_bottom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vg <= 1'b0;
        end else if (en) begin
            r_vg <= d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_tag    <= d2_side.tag;
            r_g_vis    <= d2_side.vis;
            r_g_ty     <= d2_side.ty;
            r_g_size   <= d2_quo[1];
            r_g_left   <= scr_x - half_sz;
            r_g_right  <= scr_x + half_sz;
            r_g_top    <= 34'(HALF_H) - half_sz + vsh;
            r_g_bottom <= 34'(HALF_H) + half_sz + vsh;
        end
    end

    // Stage H: saturation, clipping and the output register.
    t_sprite_out        n_out;
    logic signed [15:0] s_left, s_right, s_top, s_bottom;

    assign s_left   = sat16(r_g_left);
    assign s_right  = sat16(r_g_right);
    assign s_top    = sat16(r_g_top);
    assign s_bottom = sat16(r_g_bottom);

    always_comb begin
        n_out         = '0;
        n_out.tag_out = r_g_tag;
        if (r_g_vis) begin
            n_out.visible      = 1'b1;
            n_out.depth        = (r_g_ty > DEN2_W'(31'h7fff_ffff)) ? 31'h7fff_ffff
                                                                    : r_g_ty[30:0];
            n_out.sprite_size  = (r_g_size > Q2_W'(15'h7fff)) ? 15'h7fff : r_g_size[14:0];
            n_out.bound_left   = s_left;
            n_out.bound_right  = s_right;
            n_out.bound_top    = s_top;
            n_out.bound_bottom = s_bottom;
            n_out.clip_left    = (s_left < 16'sd0) ? 16'sd0 : s_left;
            n_out.clip_right   = (s_right > 16'(SCREEN_WIDTH - 1)) ?
                                 16'(SCREEN_WIDTH - 1) : s_right;
            n_out.clip_top     = (s_top < 16'sd0) ? 16'sd0 : s_top;
            n_out.clip_bottom  = (s_bottom > 16'(SCREEN_HEIGHT - 1)) ?
                                 16'(SCREEN_HEIGHT - 1) : s_bottom;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_vg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

endmodule

@@ rtl/scp_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per stage, several lanes sharing a divisor.
module scp_div_pipe #(
    parameter int QW = 48,
    parameter int RW = 49,
    parameter int LN = 2,
    parameter int SW = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [SW-1:0]         i_side,
    input  logic [RW-1:0]         i_den,
    input  logic [LN-1:0][RW-1:0] i_rem,
    input  logic [LN-1:0][QW-1:0] i_quo,
    output logic                  o_valid,
    output logic [SW-1:0]         o_side,
    output logic [LN-1:0][QW-1:0] o_quo
);

    logic                  r_valid [QW];
    logic [SW-1:0]         r_side  [QW];
    logic [LN-1:0][QW-1:0] r_quo   [QW];
    logic [RW-1:0]         r_den   [QW-1];
    logic [LN-1:0][RW-1:0] r_rem   [QW-1];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic                  s_valid;
        logic [SW-1:0]         s_side;
        logic [RW-1:0]         s_den;
        logic [LN-1:0][RW-1:0] s_rem;
        logic [LN-1:0][QW-1:0] s_quo;
        logic [LN-1:0][RW-1:0] n_rem;
        logic [LN-1:0][QW-1:0] n_quo;

        if (k == 0) begin : g_first
            assign s_valid = i_valid;
            assign s_side  = i_side;
            assign s_den   = i_den;
            assign s_rem   = i_rem;
            assign s_quo   = i_quo;
        end else begin : g_next
            assign s_valid = r_valid[k-1];
            assign s_side  = r_side[k-1];
            assign s_den   = r_den[k-1];
            assign s_rem   = r_rem[k-1];
            assign s_quo   = r_quo[k-1];
        end

        // Shift in the next dividend bit and subtract the divisor where it fits.
        always_comb begin
            for (int l = 0; l < LN; l++) begin
                logic [RW:0] t;
                logic        qbit;
                t = {s_rem[l], s_quo[l][QW-1]};
                if (t >= {1'b0, s_den}) begin
                    n_rem[l] = RW'(t - {1'b0, s_den});
                    qbit     = 1'b1;
                end else begin
                    n_rem[l] = t[RW-1:0];
                    qbit     = 1'b0;
                end
                n_quo[l] = {s_quo[l][QW-2:0], qbit};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= s_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= s_side;
                r_quo[k]  <= n_quo;
            end
        end

        // The last step keeps only the quotient, the valid bit and the sideband.
        if (k < QW - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[k] <= s_den;
                    r_rem[k] <= n_rem;
                end
            end
        end
    end

    assign o_valid = r_valid[QW-1];
    assign o_side  = r_side[QW-1];
    assign o_quo   = r_quo[QW-1];

endmodule

@@ rtl/scp_checker.sv @@
// Port-level checks of the sprite camera projection block, bound to its top level.
module scp_checker
    import scp_pkg::*;
#(
    parameter int SCREEN_WIDTH = 1024
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input t_sprite_out i_out_data
);

    // A result held back by the receiver stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    // Input back-pressure only comes from a stalled output.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled without an output stall");

    // An invisible sprite carries zeros in depth, size, bound_left, bound_bottom, clip_right and clip_top.
    a_invisible_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.visible |->
            i_out_data.depth == '0 && i_out_data.sprite_size == '0 &&
            i_out_data.bound_left == '0 && i_out_data.bound_bottom == '0 &&
            i_out_data.clip_right == '0 && i_out_data.clip_top == '0)
        else $error("invisible sprite with nonzero fields");

    // A visible sprite has positive depth and ordered bounds.
    a_visible_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.visible |->
            i_out_data.depth != '0 &&
            i_out_data.bound_left <= i_out_data.bound_right &&
            i_out_data.bound_top <= i_out_data.bound_bottom)
        else $error("visible sprite with bad depth or bounds");

    // Clipped bounds stay within the screen on the left, right and top sides.
    a_clip_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.visible |->
            i_out_data.clip_left >= 16'sd0 &&
            i_out_data.clip_right <= 16'(SCREEN_WIDTH - 1) &&
            i_out_data.clip_top >= 16'sd0)
        else $error("clipped bound outside the screen");

endmodule

bind sprite_camera_projection scp_checker #(
    .SCREEN_WIDTH (SCREEN_WIDTH)
) u_scp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_sprite.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_data  (o_result.data)
);
